// File: sv/bis_pkg.sv
package bis_pkg;

  // Fixed field widths of the request and result beats.
  localparam int COL_BITS = 10;
  localparam int ROW_BITS = 9;
  localparam int PIX_BITS = 8;

  // Configuration register widths and the port that carries them.
  localparam int SRC_WIDTH_BITS  = 11;
  localparam int SRC_HEIGHT_BITS = 10;
  localparam int STEP_BITS       = 26;
  localparam int STEP_FRAC_BITS  = 16;
  localparam int CFG_DATA_BITS   = 26;
  localparam int CFG_INDEX_BITS  = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_X_STEP     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_STEP     = 2'd3;

  // Values the registers take at reset.
  localparam logic [SRC_WIDTH_BITS-1:0]  SRC_WIDTH_RESET  = 11'd640;
  localparam logic [SRC_HEIGHT_BITS-1:0] SRC_HEIGHT_RESET = 10'd480;
  localparam logic [STEP_BITS-1:0]       X_STEP_RESET     = 26'd65536;
  localparam logic [STEP_BITS-1:0]       Y_STEP_RESET     = 26'd65536;

  // Request kinds.
  typedef enum logic [0:0] {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } bis_req_t;

  // One request beat.
  typedef struct packed {
    bis_req_t              req_type;
    logic [COL_BITS-1:0]   col;
    logic [ROW_BITS-1:0]   row;
    logic [PIX_BITS-1:0]   pixel_in;
  } bis_in_t;

  // One result beat.
  typedef struct packed {
    logic [PIX_BITS-1:0]   out_pixel;
    logic [COL_BITS-1:0]   out_col;
    logic [ROW_BITS-1:0]   out_row;
  } bis_out_t;

endpackage

// File: sv/bilinear_image_scaler_top.sv
// Bilinear grey image scaler. A beat on the request port is taken at every
// rising edge at which start is high; busy is held low, so one request is
// accepted every clock cycle with no gaps. A load request writes one source
// pixel (ignored when outside the configured source size); a compute request
// returns one interpolated pixel on out_data, marked by out_valid for a
// single cycle. Results come out in request order and the receiver cannot
// stall them. The rate of one pixel per clock is set by the image store,
// which is split into four banks by the parity of column and row so that
// the four neighbours of any position are read in the same cycle from
// banks with one read port each. Loads and reads use the
// store in the same pipeline stage, so a compute sees every load accepted
// before it. Store contents are undefined until written, and there is no
// clearing pass after reset. Configuration is written through cfg_we,
// cfg_index and cfg_data and takes effect at once; change it only while no
// request is in flight.
module bilinear_image_scaler_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 512,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bis_pkg::bis_in_t                    in_data,
  output logic                                out_valid,
  output bis_pkg::bis_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import bis_pkg::*;

  // Coordinate and bank geometry.
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XHW   = (XW > 1) ? XW - 1 : 1;
  localparam int YHW   = (YW > 1) ? YW - 1 : 1;
  localparam int AW    = XHW + YHW;
  localparam int DEPTH = 2 ** AW;

  // Fixed-point widths.
  localparam int PXW = COL_BITS + STEP_BITS;
  localparam int PYW = ROW_BITS + STEP_BITS;
  localparam int IXW = PXW - STEP_FRAC_BITS;
  localparam int IYW = PYW - STEP_FRAC_BITS;
  localparam int WB1 = WEIGHT_BITS + 1;
  localparam int WPW = 2 * WEIGHT_BITS + 1;
  localparam int PPW = PIX_BITS + WPW;
  localparam int SMW = PPW + 2;
  localparam logic [WB1-1:0] ONE = WB1'(1) << WEIGHT_BITS;

  // Configuration registers.
  logic [SRC_WIDTH_BITS-1:0]  src_width_r;
  logic [SRC_HEIGHT_BITS-1:0] src_height_r;
  logic [STEP_BITS-1:0]       x_step_r;
  logic [STEP_BITS-1:0]       y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RESET;
      src_height_r <= SRC_HEIGHT_RESET;
      x_step_r     <= X_STEP_RESET;
      y_step_r     <= Y_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SRC_WIDTH_BITS-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SRC_HEIGHT_BITS-1:0];
        CFG_X_STEP:     x_step_r     <= cfg_data[STEP_BITS-1:0];
        CFG_Y_STEP:     y_step_r     <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Last valid column and row: a zero size counts as one, an oversized one
  // as the store's limit.
  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;

  always_comb begin
    if (src_width_r == '0) begin
      last_x = '0;
    end else if (32'(src_width_r) > MAX_WIDTH) begin
      last_x = XW'(MAX_WIDTH - 1);
    end else begin
      last_x = XW'(src_width_r - SRC_WIDTH_BITS'(1));
    end
    if (src_height_r == '0) begin
      last_y = '0;
    end else if (32'(src_height_r) > MAX_HEIGHT) begin
      last_y = YW'(MAX_HEIGHT - 1);
    end else begin
      last_y = YW'(src_height_r - SRC_HEIGHT_BITS'(1));
    end
  end

  // The store never holds the pipeline back.
  assign busy = 1'b0;

  // Stage 1: registered request beat.
  logic          s1_valid_r;
  bis_in_t       s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= in_data;
  end

  // Stage 2: source position as coordinate times step.
  logic            s2_valid_r;
  bis_in_t         s2_data_r;
  logic [PXW-1:0]  s2_px_r;
  logic [PYW-1:0]  s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_data_r <= s1_data_r;
    s2_px_r   <= PXW'(s1_data_r.col) * PXW'(x_step_r);
    s2_py_r   <= PYW'(s1_data_r.row) * PYW'(y_step_r);
  end

  // Clamp the base and its right and lower neighbours to the source edges.
  logic [IXW-1:0]         ix;
  logic [IYW-1:0]         iy;
  logic [WEIGHT_BITS-1:0] fx;
  logic [WEIGHT_BITS-1:0] fy;
  logic [XW-1:0]          x0;
  logic [XW-1:0]          x1;
  logic [YW-1:0]          y0;
  logic [YW-1:0]          y1;

  always_comb begin
    ix = s2_px_r[PXW-1:STEP_FRAC_BITS];
    iy = s2_py_r[PYW-1:STEP_FRAC_BITS];
    fx = s2_px_r[STEP_FRAC_BITS-1:STEP_FRAC_BITS-WEIGHT_BITS];
    fy = s2_py_r[STEP_FRAC_BITS-1:STEP_FRAC_BITS-WEIGHT_BITS];
    x0 = (32'(ix) > 32'(last_x)) ? last_x : XW'(ix);
    x1 = (32'(ix) >= 32'(last_x)) ? last_x : XW'(ix + IXW'(1));
    y0 = (32'(iy) > 32'(last_y)) ? last_y : YW'(iy);
    y1 = (32'(iy) >= 32'(last_y)) ? last_y : YW'(iy + IYW'(1));
  end

  // Interpolation weights from the fractions.
  logic [WB1-1:0]   wx0;
  logic [WB1-1:0]   wx1;
  logic [WB1-1:0]   wy0;
  logic [WB1-1:0]   wy1;
  logic [2*WB1-1:0] w00;
  logic [2*WB1-1:0] w10;
  logic [2*WB1-1:0] w01;
  logic [2*WB1-1:0] w11;

  always_comb begin
    wx1 = WB1'(fx);
    wy1 = WB1'(fy);
    wx0 = ONE - wx1;
    wy0 = ONE - wy1;
    w00 = (2*WB1)'(wx0) * (2*WB1)'(wy0);
    w10 = (2*WB1)'(wx1) * (2*WB1)'(wy0);
    w01 = (2*WB1)'(wx0) * (2*WB1)'(wy1);
    w11 = (2*WB1)'(wx1) * (2*WB1)'(wy1);
  end

  // Load beats write the store in this stage when inside the source image.
  logic          load_en;
  logic [XW-1:0] load_x;
  logic [YW-1:0] load_y;

  always_comb begin
    load_x  = XW'(s2_data_r.col);
    load_y  = YW'(s2_data_r.row);
    load_en = s2_valid_r && (s2_data_r.req_type == REQ_LOAD)
              && (32'(s2_data_r.col) <= 32'(last_x))
              && (32'(s2_data_r.row) <= 32'(last_y));
  end

  // Four banks split by row and column parity; bank index is {row, col} lsb.
  logic [PIX_BITS-1:0] bank_rd_data [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);

    logic [XW-1:0] xsel;
    logic [YW-1:0] ysel;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    // Read whichever of the two columns and rows falls in this bank.
    always_comb begin
      xsel    = (x0[0] == BX) ? x0 : x1;
      ysel    = (y0[0] == BY) ? y0 : y1;
      rd_addr = {YHW'(ysel >> 1), XHW'(xsel >> 1)};
      wr_addr = {YHW'(load_y >> 1), XHW'(load_x >> 1)};
      wr_en   = load_en && (load_x[0] == BX) && (load_y[0] == BY);
    end

    bis_ram #(
      .WIDTH(PIX_BITS),
      .DEPTH(DEPTH)
    ) u_bank (
      .clk    (clk),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(s2_data_r.pixel_in),
      .rd_addr(rd_addr),
      .rd_data(bank_rd_data[b])
    );
  end

  // Stage 3: bank data arrives; weights and neighbour parities travel along.
  logic                 s3_valid_r;
  logic [COL_BITS-1:0]  s3_col_r;
  logic [ROW_BITS-1:0]  s3_row_r;
  logic                 s3_x0p_r;
  logic                 s3_x1p_r;
  logic                 s3_y0p_r;
  logic                 s3_y1p_r;
  logic [WPW-1:0]       s3_w00_r;
  logic [WPW-1:0]       s3_w10_r;
  logic [WPW-1:0]       s3_w01_r;
  logic [WPW-1:0]       s3_w11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r && (s2_data_r.req_type == REQ_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    s3_col_r <= s2_data_r.col;
    s3_row_r <= s2_data_r.row;
    s3_x0p_r <= x0[0];
    s3_x1p_r <= x1[0];
    s3_y0p_r <= y0[0];
    s3_y1p_r <= y1[0];
    s3_w00_r <= w00[WPW-1:0];
    s3_w10_r <= w10[WPW-1:0];
    s3_w01_r <= w01[WPW-1:0];
    s3_w11_r <= w11[WPW-1:0];
  end

  // Pick each neighbour from its bank and weight it.
  logic [PIX_BITS-1:0] p00;
  logic [PIX_BITS-1:0] p10;
  logic [PIX_BITS-1:0] p01;
  logic [PIX_BITS-1:0] p11;

  always_comb begin
    p00 = bank_rd_data[{s3_y0p_r, s3_x0p_r}];
    p10 = bank_rd_data[{s3_y0p_r, s3_x1p_r}];
    p01 = bank_rd_data[{s3_y1p_r, s3_x0p_r}];
    p11 = bank_rd_data[{s3_y1p_r, s3_x1p_r}];
  end

  // Stage 4: the four weighted terms.
  logic                 s4_valid_r;
  logic [COL_BITS-1:0]  s4_col_r;
  logic [ROW_BITS-1:0]  s4_row_r;
  logic [PPW-1:0]       s4_t00_r;
  logic [PPW-1:0]       s4_t10_r;
  logic [PPW-1:0]       s4_t01_r;
  logic [PPW-1:0]       s4_t11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_col_r <= s3_col_r;
    s4_row_r <= s3_row_r;
    s4_t00_r <= PPW'(p00) * PPW'(s3_w00_r);
    s4_t10_r <= PPW'(p10) * PPW'(s3_w10_r);
    s4_t01_r <= PPW'(p01) * PPW'(s3_w01_r);
    s4_t11_r <= PPW'(p11) * PPW'(s3_w11_r);
  end

  // Sum the terms and drop the weight fraction bits.
  logic [SMW-1:0] sum;

  always_comb begin
    sum = SMW'(s4_t00_r) + SMW'(s4_t10_r) + SMW'(s4_t01_r) + SMW'(s4_t11_r);
  end

  // Stage 5: result register, shown for one cycle per compute beat.
  logic      out_valid_r;
  bis_out_t  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_pixel <= sum[2*WEIGHT_BITS +: PIX_BITS];
    out_data_r.out_col   <= s4_col_r;
    out_data_r.out_row   <= s4_row_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/bis_ram.sv
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; the read data is registered and shows
  // the old contents when both ports hit the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bis_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 512;
  localparam int WB = 8;
  localparam int IMG_DEPTH = MAX_W * MAX_H;
  localparam longint unsigned WEIGHT_ONE = 64'd1 << WB;
  localparam longint unsigned FRAC_MASK = (64'd1 << STEP_FRAC_BITS) - 1;
  // Idle margin allowed once every result is in.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 225;
  localparam int NUM_PHASES = 8;
  localparam int MAX_REPORTS = 10;

  // Bilinear predictor with its own copy of the image store and registers.
  class scaler_scoreboard;
    byte unsigned image [IMG_DEPTH];
    bit stored [IMG_DEPTH];
    int unsigned width_reg = SRC_WIDTH_RESET;
    int unsigned height_reg = SRC_HEIGHT_RESET;
    longint unsigned x_step_reg = X_STEP_RESET;
    longint unsigned y_step_reg = Y_STEP_RESET;
    bis_out_t pending [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned loads_done = 0;
    int unsigned computes_done = 0;

    // A zero size counts as one, and a size past the store counts as the store.
    function int unsigned clamp_size(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
    endfunction

    function int unsigned eff_width();
      return clamp_size(width_reg, MAX_W);
    endfunction

    function int unsigned eff_height();
      return clamp_size(height_reg, MAX_H);
    endfunction

    function int addr_of(longint unsigned x, longint unsigned y);
      return int'(y) * MAX_W + int'(x);
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_SRC_WIDTH: width_reg = data[SRC_WIDTH_BITS-1:0];
        CFG_SRC_HEIGHT: height_reg = data[SRC_HEIGHT_BITS-1:0];
        CFG_X_STEP: x_step_reg = data[STEP_BITS-1:0];
        CFG_Y_STEP: y_step_reg = data[STEP_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Maps a destination pixel to its four clamped source neighbours and weights.
    function void locate(input int unsigned col, input int unsigned row,
                         output longint unsigned x0, output longint unsigned x1,
                         output longint unsigned y0, output longint unsigned y1,
                         output longint unsigned fx, output longint unsigned fy);
      longint unsigned px, py, ix, iy, last_x, last_y;
      px = col;
      py = row;
      px = px * x_step_reg;
      py = py * y_step_reg;
      ix = px >> STEP_FRAC_BITS;
      iy = py >> STEP_FRAC_BITS;
      fx = (px & FRAC_MASK) >> (STEP_FRAC_BITS - WB);
      fy = (py & FRAC_MASK) >> (STEP_FRAC_BITS - WB);
      last_x = eff_width() - 1;
      last_y = eff_height() - 1;
      x0 = (ix > last_x) ? last_x : ix;
      x1 = (ix + 1 > last_x) ? last_x : ix + 1;
      y0 = (iy > last_y) ? last_y : iy;
      y1 = (iy + 1 > last_y) ? last_y : iy + 1;
    endfunction

    // Takes an accepted beat; returns whether the block acts on it.
    function bit note_request(bis_in_t b);
      longint unsigned x0, x1, y0, y1, fx, fy, sum;
      bis_out_t res;
      if (b.req_type == REQ_LOAD) begin
        if (b.col >= eff_width() || b.row >= eff_height()) return 1'b0;
        image[addr_of(b.col, b.row)] = b.pixel_in;
        stored[addr_of(b.col, b.row)] = 1'b1;
        loads_done++;
        return 1'b1;
      end
      locate(b.col, b.row, x0, x1, y0, y1, fx, fy);
      sum = image[addr_of(x0, y0)] * ((WEIGHT_ONE - fx) * (WEIGHT_ONE - fy))
          + image[addr_of(x1, y0)] * (fx * (WEIGHT_ONE - fy))
          + image[addr_of(x0, y1)] * ((WEIGHT_ONE - fx) * fy)
          + image[addr_of(x1, y1)] * (fx * fy);
      res.out_pixel = PIX_BITS'(sum >> (2 * WB));
      res.out_col = b.col;
      res.out_row = b.row;
      pending.push_back(res);
      computes_done++;
      return 1'b1;
    endfunction

    function void flag(string what, bis_out_t want, bis_out_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: expected pixel %0d col %0d row %0d, got pixel %0d col %0d row %0d",
                 what, want.out_pixel, want.out_col, want.out_row,
                 got.out_pixel, got.out_col, got.out_row);
    endfunction

    function void check_result(bis_out_t got);
      bis_out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        flag("Unexpected result", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.out_pixel !== want.out_pixel || got.out_col !== want.out_col ||
          got.out_row !== want.out_row)
        flag("Result mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  bis_in_t in_data;
  logic out_valid;
  bis_out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  scaler_scoreboard sb = new;
  int unsigned sender_idle_pct = 20;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;

  bilinear_image_scaler_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Guards against a block that stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function bis_in_t make_beat(bis_req_t kind, int unsigned col, int unsigned row,
                              int unsigned pix);
    bis_in_t b;
    b.req_type = kind;
    b.col = COL_BITS'(col);
    b.row = ROW_BITS'(row);
    b.pixel_in = PIX_BITS'(pix);
    return b;
  endfunction

  // Largest coordinate whose position still falls inside the source, plus one.
  function int unsigned reach(int unsigned size, longint unsigned step, int unsigned limit);
    longint unsigned span;
    if (step == 0) return limit;
    span = ((longint'(size) << STEP_FRAC_BITS) / step) + 1;
    return (span > limit) ? limit : int'(span);
  endfunction

  // Drives one request beat, with random idle cycles ahead of it.
  task automatic send_beat(bis_in_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    if (sb.note_request(b)) items_sent++;
  endtask

  // Loads any neighbour not yet written, then asks for the destination pixel.
  task automatic compute_at(int unsigned col, int unsigned row);
    longint unsigned xs [2];
    longint unsigned ys [2];
    longint unsigned fx, fy;
    sb.locate(col, row, xs[0], xs[1], ys[0], ys[1], fx, fy);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!sb.stored[sb.addr_of(xs[i], ys[j])])
          send_beat(make_beat(REQ_LOAD, 32'(xs[i]), 32'(ys[j]), $urandom_range(255)));
      end
    end
    send_beat(make_beat(REQ_COMPUTE, col, row, $urandom_range(255)));
  endtask

  // Holds requests back until every result is in and the pipeline is empty.
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned xs, int unsigned ys);
    logic [CFG_DATA_BITS-1:0] vals [4];
    logic [CFG_INDEX_BITS-1:0] idx [4];
    vals = '{CFG_DATA_BITS'(w), CFG_DATA_BITS'(h), CFG_DATA_BITS'(xs), CFG_DATA_BITS'(ys)};
    idx = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_X_STEP, CFG_Y_STEP};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly computes, inside the source or anywhere, plus loads and stray writes.
  task automatic random_phase(int unsigned count);
    int unsigned first, pick, ew, eh, reach_x, reach_y;
    first = items_sent;
    ew = sb.eff_width();
    eh = sb.eff_height();
    reach_x = reach(ew, sb.x_step_reg, MAX_W - 1);
    reach_y = reach(eh, sb.y_step_reg, MAX_H - 1);
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 25)
        compute_at($urandom_range(MAX_W - 1), $urandom_range(MAX_H - 1));
      else if (pick < 65)
        compute_at($urandom_range(reach_x), $urandom_range(reach_y));
      else if (pick < 85)
        send_beat(make_beat(REQ_LOAD, $urandom_range(ew - 1), $urandom_range(eh - 1),
                            $urandom_range(255)));
      else
        send_beat(make_beat(REQ_LOAD, $urandom_range(MAX_W - 1), $urandom_range(MAX_H - 1),
                            $urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned phase_w [NUM_PHASES] = '{16, 0, 2047, 1024, 37, 1, 1024, 5};
    int unsigned phase_h [NUM_PHASES] = '{8, 0, 1023, 512, 23, 512, 1, 3};
    int unsigned phase_xs [NUM_PHASES] =
      '{32'h08000, 32'h3FFFFFF, 32'h20000, 32'h00001, 32'h0A3D7, 32'h0, 32'h18000, 32'h0};
    int unsigned phase_ys [NUM_PHASES] =
      '{32'h0C000, 32'h3FFFFFF, 32'h35555, 32'h00100, 32'h1547A, 32'h08000, 32'h3FFFFFF, 32'h0};
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset settings: corners, clamping and ignored loads.
    send_beat(make_beat(REQ_LOAD, 0, 0, 8'h00));
    send_beat(make_beat(REQ_LOAD, 1, 0, 8'hFF));
    send_beat(make_beat(REQ_LOAD, 0, 1, 8'hAA));
    send_beat(make_beat(REQ_LOAD, 1, 1, 8'h55));
    send_beat(make_beat(REQ_COMPUTE, 0, 0, 8'hFF));
    compute_at(1, 1);
    send_beat(make_beat(REQ_LOAD, 639, 479, 8'hFF));
    compute_at(MAX_W - 1, MAX_H - 1);
    send_beat(make_beat(REQ_LOAD, 640, 0, 8'h12));
    send_beat(make_beat(REQ_LOAD, 0, 480, 8'h34));
    send_beat(make_beat(REQ_LOAD, MAX_W - 1, MAX_H - 1, 8'hFF));
    send_beat(make_beat(REQ_COMPUTE, 0, 0, 8'h00));
    quiesce();

    // Largest weights: a step just under one gives fractions of all ones.
    configure(640, 480, 32'h0FFFF, 32'h0FFFF);
    for (int i = 0; i < 4; i++) send_beat(make_beat(REQ_LOAD, i % 2, i / 2, 8'hFF));
    send_beat(make_beat(REQ_COMPUTE, 1, 1, 8'h00));
    send_beat(make_beat(REQ_LOAD, 0, 0, 8'h00));
    send_beat(make_beat(REQ_COMPUTE, 1, 1, 8'h00));
    send_beat(make_beat(REQ_COMPUTE, 0, 0, 8'h00));
    quiesce();
    items_sent = 0;

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = (p < 3) ? 20 : (p < 6) ? 81 : 0;
      if (p == NUM_PHASES - 1)
        configure($urandom_range(64), $urandom_range(32), $urandom_range(32'h3FFFF),
                  $urandom_range(32'h3FFFF));
      else
        configure(phase_w[p], phase_h[p], phase_xs[p], phase_ys[p]);
      random_phase(PHASE_ITEMS);
      quiesce();
    end

    $display("Covered %0d stored loads and %0d computes under %0d register settings,",
             sb.loads_done, sb.computes_done, settings_used);
    $display("with zero, oversized and extreme sizes and steps; %0d results checked.",
             sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bis_pkg.sv
sv/bis_ram.sv
sv/bilinear_image_scaler_top.sv
dv/testbench.sv
